// File: rtl/pfc_pkg.sv
// ---------------------------------------------------------------------------
// pfc_pkg: shared types, constants and the decision tree
// Field widths, header offsets, verdict codes, register indexes and the
// fixed tree classifier used by the packet filter.
// ---------------------------------------------------------------------------
package pfc_pkg;

	// defaults for the top-level parameters
	localparam int unsigned MAX_FRAME_BYTES_DEF = 65535;
	localparam int unsigned PORT_TABLE_SIZE_DEF = 4;

	// field widths
	localparam int unsigned BYTE_W     = 8;
	localparam int unsigned LEN_W      = 16;
	localparam int unsigned ETYPE_W    = 16;
	localparam int unsigned PROTO_W    = 8;
	localparam int unsigned ADDR_W     = 32;
	localparam int unsigned PORT_W     = 16;
	localparam int unsigned SCORE_W    = 40;
	localparam int unsigned REASON_W   = 3;
	localparam int unsigned COUNT_W    = 3;
	localparam int unsigned CFG_IDX_W  = 3;
	localparam int unsigned CFG_DATA_W = 32;
	localparam int unsigned WORDS_W    = 17;

	// header byte offsets, counted from the destination MAC
	localparam int unsigned POS_ETYPE_HI = 12;
	localparam int unsigned POS_ETYPE_LO = 13;
	localparam int unsigned POS_PROTO    = 23;
	localparam int unsigned POS_SADDR_LO = 26;
	localparam int unsigned POS_SADDR_HI = 29;
	localparam int unsigned POS_SPORT_HI = 34;
	localparam int unsigned POS_SPORT_LO = 35;
	localparam int unsigned POS_DPORT_LO = 36;
	localparam int unsigned POS_DPORT_HI = 37;

	// minimum lengths for each header layer
	localparam int unsigned MIN_ETH_LEN  = 14;
	localparam int unsigned MIN_IPV4_LEN = 34;
	localparam int unsigned MIN_UDP_LEN  = 42;
	localparam int unsigned MIN_TCP_LEN  = 54;

	localparam logic [ETYPE_W-1:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [PROTO_W-1:0] PROTO_TCP      = 8'd6;
	localparam logic [PROTO_W-1:0] PROTO_UDP      = 8'd17;
	localparam logic [PORT_W-1:0]  HTTP_PORT      = 16'd80;

	// verdict reason codes
	typedef enum logic [REASON_W-1:0] {
		RSN_HEADER       = 3'd0,
		RSN_BLOCKED_ADDR = 3'd1,
		RSN_SHORT_L4     = 3'd2,
		RSN_PORT_MISSING = 3'd3,
		RSN_BLOCKED_PORT = 3'd4,
		RSN_CLASS_DROP   = 3'd5,
		RSN_CLASS_PASS   = 3'd6
	} reason_t;

	// configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_BLOCKED_ADDR = 3'd0,
		CFG_ADDR_EN      = 3'd1,
		CFG_PORT_COUNT   = 3'd2,
		CFG_PORT_A       = 3'd3,
		CFG_PORT_B       = 3'd4,
		CFG_PORT_C       = 3'd5,
		CFG_PORT_D       = 3'd6,
		CFG_CLASS_DROP   = 3'd7
	} cfg_idx_t;

	// captured header of one finished frame
	typedef struct packed {
		logic [LEN_W-1:0]   length;
		logic [ETYPE_W-1:0] ether_type;
		logic [PROTO_W-1:0] ip_protocol;
		logic [ADDR_W-1:0]  source_addr;
		logic [PORT_W-1:0]  source_port;
		logic [PORT_W-1:0]  dest_port_swapped;
	} hdr_t;

	// leaf scores of the tree
	typedef struct packed {
		logic [SCORE_W-1:0] keep;
		logic [SCORE_W-1:0] drop;
	} score_t;

	function automatic score_t mk_score(input logic [SCORE_W-1:0] a,
			input logic [SCORE_W-1:0] b);
		score_t s;
		s.keep = a;
		s.drop = b;
		return s;
	endfunction

	// fixed decision tree: w = length in 4-byte words, p = swapped dest
	// port, f = source port is 80
	function automatic score_t tree_score(input logic [WORDS_W-1:0] w,
			input logic [PORT_W-1:0] p, input logic f);
		score_t s;
		if (w <= 17'd2027) begin
			if (w <= 17'd149) begin
				if (p <= 16'd62531) begin
					if (!f) s = mk_score(40'd1000000000, 40'd0);
					else if (w <= 17'd37) begin
						if (p <= 16'd50853)
							s = mk_score(40'd843949044586, 40'd156050955414);
						else if (p <= 16'd56777)
							s = mk_score(40'd593541202673, 40'd406458797327);
						else
							s = mk_score(40'd785591766724, 40'd214408233276);
					end else s = mk_score(40'd258620689655, 40'd741379310345);
				end else s = mk_score(40'd238805970149, 40'd761194029851);
			end else if (w <= 17'd240) begin
				if (!f) s = mk_score(40'd1000000000, 40'd0);
				else if (p <= 16'd48860) s = mk_score(40'd1000000000, 40'd0);
				else s = mk_score(40'd325594563399, 40'd967440543601);
			end else if (p <= 16'd56648) begin
				if (p <= 16'd48860) s = mk_score(40'd1000000000, 40'd0);
				else if (w <= 17'd1099) begin
					if (w <= 17'd384) begin
						if (w <= 17'd383)
							s = mk_score(40'd483760683761, 40'd516239316239);
						else
							s = mk_score(40'd127462340672, 40'd987253765933);
					end else if (p <= 16'd55209)
						s = mk_score(40'd681118083286, 40'd318881916714);
					else
						s = mk_score(40'd247011952191, 40'd752988047809);
				end else if (w <= 17'd1151)
					s = mk_score(40'd416666666667, 40'd958333333333);
				else if (w <= 17'd1909)
					s = mk_score(40'd551794871795, 40'd448205128205);
				else
					s = mk_score(40'd451467268862, 40'd954853273138);
			end else if (w <= 17'd1934) begin
				if (w <= 17'd402) begin
					if (w <= 17'd383)
						s = mk_score(40'd880851063830, 40'd119148936170);
					else
						s = mk_score(40'd172413793103, 40'd827586206897);
				end else if (p <= 16'd57205) begin
					if (w <= 17'd961)
						s = mk_score(40'd878151260504, 40'd121848739496);
					else
						s = mk_score(40'd236842105263, 40'd763157894737);
				end else s = mk_score(40'd934684684685, 40'd653153153153);
			end else if (w <= 17'd1943)
				s = mk_score(40'd512820512820, 40'd994871794872);
			else
				s = mk_score(40'd100000000000, 40'd0);
		end else if (p <= 16'd56929) begin
			if (p <= 16'd55262) begin
				if (p <= 16'd49283)
					s = mk_score(40'd980337078652, 40'd196629213348);
				else if (w <= 17'd19375) begin
					if (w <= 17'd3037)
						s = mk_score(40'd829015544041, 40'd170984455959);
					else if (p <= 16'd49944)
						s = mk_score(40'd531468531469, 40'd468531468531);
					else if (p <= 16'd50370)
						s = mk_score(40'd949367088608, 40'd506329113924);
					else
						s = mk_score(40'd641937925814, 40'd358062074186);
				end else s = mk_score(40'd846780766096, 40'd153219233904);
			end else if (p <= 16'd56438)
				s = mk_score(40'd369127516779, 40'd963087248322);
			else
				s = mk_score(40'd752475247525, 40'd247524752475);
		end else if (p <= 16'd61905)
			s = mk_score(40'd987212276215, 40'd127877237851);
		else if (w <= 17'd68705)
			s = mk_score(40'd881294964029, 40'd118705035971);
		else
			s = mk_score(40'd198198198198, 40'd801801801802);
		return s;
	endfunction

endpackage

// File: rtl/pfc_in_if.sv
// ---------------------------------------------------------------------------
// pfc_in_if: frame byte stream
// One beat carries one frame byte and its end-of-frame mark.
// ---------------------------------------------------------------------------
interface pfc_in_if;
	import pfc_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] frame_byte;
	logic              last_byte;

	modport source (output valid, output frame_byte, output last_byte, input ready);
	modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

// File: rtl/pfc_out_if.sv
// ---------------------------------------------------------------------------
// pfc_out_if: verdict stream
// One beat carries the verdict of one frame and the tree scores.
// ---------------------------------------------------------------------------
interface pfc_out_if;
	import pfc_pkg::*;

	logic                valid;
	logic                ready;
	logic                drop;
	logic [REASON_W-1:0] reason;
	logic [SCORE_W-1:0]  score_keep;
	logic [SCORE_W-1:0]  score_drop;

	modport source (output valid, output drop, output reason, output score_keep,
		output score_drop, input ready);
	modport sink   (input valid, input drop, input reason, input score_keep,
		input score_drop, output ready);
endinterface

// File: rtl/pfc_hdr_capture.sv
// ---------------------------------------------------------------------------
// pfc_hdr_capture: header field capture and length count
// Pulls header fields out of the byte stream at fixed offsets, counts the
// frame length with saturation and hands the finished header on.
// ---------------------------------------------------------------------------
module pfc_hdr_capture #(
	parameter int unsigned MAX_FRAME_BYTES = pfc_pkg::MAX_FRAME_BYTES_DEF
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       take,
	input  logic [pfc_pkg::BYTE_W-1:0] frame_byte,
	input  logic                       last_byte,
	input  logic                       hdr_advance,
	output logic                       hdr_valid_s1,
	output pfc_pkg::hdr_t              hdr_s1
);
	import pfc_pkg::*;

	localparam int unsigned CNT_W = $clog2(MAX_FRAME_BYTES + 1);

	logic [CNT_W-1:0]   cnt_q, cnt_n;
	logic [ETYPE_W-1:0] etype_q, etype_n;
	logic [PROTO_W-1:0] proto_q, proto_n;
	logic [ADDR_W-1:0]  saddr_q, saddr_n;
	logic [PORT_W-1:0]  sport_q, sport_n;
	logic [PORT_W-1:0]  dport_q, dport_n;

	// field update for the byte at the current position
	always_comb begin
		etype_n = etype_q;
		proto_n = proto_q;
		saddr_n = saddr_q;
		sport_n = sport_q;
		dport_n = dport_q;
		if (cnt_q == CNT_W'(POS_ETYPE_HI)) etype_n[15:8] = frame_byte;
		else if (cnt_q == CNT_W'(POS_ETYPE_LO)) etype_n[7:0] = frame_byte;
		else if (cnt_q == CNT_W'(POS_PROTO)) proto_n = frame_byte;
		else if (cnt_q >= CNT_W'(POS_SADDR_LO) && cnt_q <= CNT_W'(POS_SADDR_HI))
			saddr_n = {saddr_q[ADDR_W-BYTE_W-1:0], frame_byte};
		else if (cnt_q == CNT_W'(POS_SPORT_HI)) sport_n[15:8] = frame_byte;
		else if (cnt_q == CNT_W'(POS_SPORT_LO)) sport_n[7:0] = frame_byte;
		else if (cnt_q == CNT_W'(POS_DPORT_LO)) dport_n[7:0] = frame_byte;
		else if (cnt_q == CNT_W'(POS_DPORT_HI)) dport_n[15:8] = frame_byte;
		// length saturates, later bytes are still taken
		cnt_n = (cnt_q < CNT_W'(MAX_FRAME_BYTES)) ? cnt_q + CNT_W'(1) : cnt_q;
	end

	// per-frame state, cleared after the last byte
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q   <= '0;
			etype_q <= '0;
			proto_q <= '0;
			saddr_q <= '0;
			sport_q <= '0;
			dport_q <= '0;
		end else if (take) begin
			if (last_byte) begin
				cnt_q   <= '0;
				etype_q <= '0;
				proto_q <= '0;
				saddr_q <= '0;
				sport_q <= '0;
				dport_q <= '0;
			end else begin
				cnt_q   <= cnt_n;
				etype_q <= etype_n;
				proto_q <= proto_n;
				saddr_q <= saddr_n;
				sport_q <= sport_n;
				dport_q <= dport_n;
			end
		end
	end

	// finished header register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hdr_valid_s1 <= 1'b0;
		end else if (take && last_byte) begin
			hdr_valid_s1 <= 1'b1;
		end else if (hdr_advance) begin
			hdr_valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && last_byte) begin
			hdr_s1.length            <= LEN_W'(cnt_n);
			hdr_s1.ether_type        <= etype_n;
			hdr_s1.ip_protocol       <= proto_n;
			hdr_s1.source_addr       <= saddr_n;
			hdr_s1.source_port       <= sport_n;
			hdr_s1.dest_port_swapped <= dport_n;
		end
	end

endmodule

// File: rtl/pfc_verdict.sv
// ---------------------------------------------------------------------------
// pfc_verdict: filter checks, tree classifier and result register
// Holds the configuration registers, runs the check chain on a finished
// header and registers the verdict for the output channel.
// ---------------------------------------------------------------------------
module pfc_verdict #(
	parameter int unsigned PORT_TABLE_SIZE = pfc_pkg::PORT_TABLE_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                           hdr_valid_s1,
	input  pfc_pkg::hdr_t                  hdr_s1,
	output logic                           hdr_advance,
	pfc_out_if.source                      verdict_out
);
	import pfc_pkg::*;

	// configuration registers
	logic [ADDR_W-1:0]  blocked_addr_q;
	logic               addr_en_q;
	logic [COUNT_W-1:0] port_count_q;
	logic               class_drop_en_q;
	logic [PORT_W-1:0]  port_tbl_q [PORT_TABLE_SIZE];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			blocked_addr_q  <= '0;
			addr_en_q       <= 1'b0;
			port_count_q    <= '0;
			class_drop_en_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_idx_t'(cfg_index))
				CFG_BLOCKED_ADDR: blocked_addr_q  <= cfg_data[ADDR_W-1:0];
				CFG_ADDR_EN:      addr_en_q       <= cfg_data[0];
				CFG_PORT_COUNT:   port_count_q    <= cfg_data[COUNT_W-1:0];
				CFG_CLASS_DROP:   class_drop_en_q <= cfg_data[0];
				default: ;
			endcase
		end
	end

	// port table, entry i at register index CFG_PORT_A + i
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < int'(PORT_TABLE_SIZE); i++) port_tbl_q[i] <= '0;
		end else if (cfg_we) begin
			for (int i = 0; i < int'(PORT_TABLE_SIZE); i++) begin
				if (cfg_index == CFG_IDX_W'(int'(CFG_PORT_A) + i))
					port_tbl_q[i] <= cfg_data[PORT_W-1:0];
			end
		end
	end

	// check chain
	logic [COUNT_W-1:0] n_eff;
	logic               port_hit;
	logic               proto_ok;
	score_t             tree_s;
	logic               drop_c;
	reason_t            reason_c;
	score_t             score_c;

	always_comb begin
		n_eff = (port_count_q > COUNT_W'(PORT_TABLE_SIZE)) ?
			COUNT_W'(PORT_TABLE_SIZE) : port_count_q;
		port_hit = 1'b0;
		for (int i = 0; i < int'(PORT_TABLE_SIZE); i++) begin
			if (COUNT_W'(i) < n_eff && hdr_s1.source_port == port_tbl_q[i])
				port_hit = 1'b1;
		end
		proto_ok = (hdr_s1.ip_protocol == PROTO_TCP &&
				hdr_s1.length >= LEN_W'(MIN_TCP_LEN)) ||
			(hdr_s1.ip_protocol == PROTO_UDP &&
				hdr_s1.length >= LEN_W'(MIN_UDP_LEN));
		tree_s = tree_score({3'b000, hdr_s1.length[LEN_W-1:2]},
			hdr_s1.dest_port_swapped, hdr_s1.source_port == HTTP_PORT);

		drop_c   = 1'b0;
		reason_c = RSN_HEADER;
		score_c  = '0;
		priority if (hdr_s1.length < LEN_W'(MIN_ETH_LEN) ||
				hdr_s1.ether_type != ETHERTYPE_IPV4 ||
				hdr_s1.length < LEN_W'(MIN_IPV4_LEN) || !proto_ok) begin
			reason_c = RSN_HEADER;
		end else if (addr_en_q && hdr_s1.source_addr == blocked_addr_q) begin
			drop_c   = 1'b1;
			reason_c = RSN_BLOCKED_ADDR;
		end else if (hdr_s1.length < LEN_W'(MIN_TCP_LEN)) begin
			reason_c = RSN_SHORT_L4;
		end else if (port_hit) begin
			drop_c   = 1'b1;
			reason_c = RSN_BLOCKED_PORT;
		end else if (n_eff != '0 && n_eff < COUNT_W'(PORT_TABLE_SIZE)) begin
			reason_c = RSN_PORT_MISSING;
		end else begin
			score_c = tree_s;
			if (class_drop_en_q && tree_s.keep < tree_s.drop) begin
				drop_c   = 1'b1;
				reason_c = RSN_CLASS_DROP;
			end else begin
				reason_c = RSN_CLASS_PASS;
			end
		end
	end

	// result register
	logic                valid_q;
	logic                drop_q;
	logic [REASON_W-1:0] reason_q;
	logic [SCORE_W-1:0]  keep_q;
	logic [SCORE_W-1:0]  dropsc_q;

	assign hdr_advance = !valid_q || verdict_out.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (hdr_advance) begin
			valid_q <= hdr_valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (hdr_advance && hdr_valid_s1) begin
			drop_q   <= drop_c;
			reason_q <= reason_c;
			keep_q   <= score_c.keep;
			dropsc_q <= score_c.drop;
		end
	end

	assign verdict_out.valid      = valid_q;
	assign verdict_out.drop       = drop_q;
	assign verdict_out.reason     = reason_q;
	assign verdict_out.score_keep = keep_q;
	assign verdict_out.score_drop = dropsc_q;

endmodule

// File: rtl/packet_filter_tree_classifier_top.sv
// ---------------------------------------------------------------------------
// packet_filter_tree_classifier_top: byte-stream packet filter
// Captures header fields of an Ethernet frame, applies the address and port
// filters and scores passing frames with a fixed decision tree.
// ---------------------------------------------------------------------------
// Throughput: one frame byte per cycle; ready drops only while a verdict
//   waits on a stalled output and the header register behind it is full.
// Verdict path: the last byte's beat loads the header register, then check
//   and tree logic load the result register that drives the verdict.
// Reset: arst_n clears the byte count, captured fields, configuration
//   registers and both valid flags; no clearing pass is needed.
module packet_filter_tree_classifier_top #(
	parameter int unsigned MAX_FRAME_BYTES = pfc_pkg::MAX_FRAME_BYTES_DEF,
	parameter int unsigned PORT_TABLE_SIZE = pfc_pkg::PORT_TABLE_SIZE_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [pfc_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pfc_pkg::CFG_DATA_W-1:0] cfg_data,
	pfc_in_if.sink                         frame_in,
	pfc_out_if.source                      verdict_out
);
	import pfc_pkg::*;

	logic hdr_valid_s1;
	hdr_t hdr_s1;
	logic hdr_advance;
	logic take;

	// header register can load when empty or being drained this cycle
	assign frame_in.ready = !hdr_valid_s1 || hdr_advance;
	assign take           = frame_in.valid && frame_in.ready;

	pfc_hdr_capture #(
		.MAX_FRAME_BYTES(MAX_FRAME_BYTES)
	) u_capture (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.frame_byte   (frame_in.frame_byte),
		.last_byte    (frame_in.last_byte),
		.hdr_advance  (hdr_advance),
		.hdr_valid_s1 (hdr_valid_s1),
		.hdr_s1       (hdr_s1)
	);

	pfc_verdict #(
		.PORT_TABLE_SIZE(PORT_TABLE_SIZE)
	) u_verdict (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.hdr_valid_s1 (hdr_valid_s1),
		.hdr_s1       (hdr_s1),
		.hdr_advance  (hdr_advance),
		.verdict_out  (verdict_out)
	);

endmodule

// File: rtl/pfc_checker.sv
// ---------------------------------------------------------------------------
// pfc_checker: port-level assertions for the packet filter
// Watches the verdict channel for held beats and consistent verdicts.
// ---------------------------------------------------------------------------
module pfc_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          out_valid,
	input logic                          out_ready,
	input logic                          out_drop,
	input logic [pfc_pkg::REASON_W-1:0]  out_reason,
	input logic [pfc_pkg::SCORE_W-1:0]   score_keep,
	input logic [pfc_pkg::SCORE_W-1:0]   score_drop
);
	import pfc_pkg::*;

	// a stalled verdict beat holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_drop) &&
			$stable(out_reason) && $stable(score_keep) && $stable(score_drop))
		else $error("verdict beat changed while stalled");

	// scores are zero unless the tree decided
	a_scores: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_reason != RSN_CLASS_DROP && out_reason != RSN_CLASS_PASS
			|-> score_keep == '0 && score_drop == '0)
		else $error("nonzero scores without tree verdict");

	// drop flag follows the reason
	a_drop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> out_drop == (out_reason == RSN_BLOCKED_ADDR ||
			out_reason == RSN_BLOCKED_PORT || out_reason == RSN_CLASS_DROP))
		else $error("drop flag disagrees with reason");

	// classifier drops only when the drop score wins
	a_class: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_reason == RSN_CLASS_DROP |-> score_keep < score_drop)
		else $error("classifier drop with keep score not below drop score");

endmodule

bind packet_filter_tree_classifier_top pfc_checker u_pfc_checker (
	.clk        (clk),
	.arst_n     (arst_n),
	.out_valid  (verdict_out.valid),
	.out_ready  (verdict_out.ready),
	.out_drop   (verdict_out.drop),
	.out_reason (verdict_out.reason),
	.score_keep (verdict_out.score_keep),
	.score_drop (verdict_out.score_drop)
);
